### hw/rtl/lpf_pkg.sv
// Shared types and constants for the LED frame stream parser.
// Used by lpf_csr and led_frame_stream_parser; depends on nothing else.
package lpf_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUFFER_CAPACITY    = 3'd0,
      CSR_START_CODE         = 3'd1,
      CSR_END_CODE           = 3'd2,
      CSR_DATA_TYPE_CODE     = 3'd3,
      CSR_COMMAND_TYPE_CODE  = 3'd4,
      CSR_RESPONSE_TYPE_CODE = 3'd5
   } csr_index_type;

   localparam logic [15:0] RST_BUFFER_CAPACITY    = 16'd512;
   localparam logic [7:0]  RST_START_CODE         = 8'd201;
   localparam logic [7:0]  RST_END_CODE           = 8'd54;
   localparam logic [7:0]  RST_DATA_TYPE_CODE     = 8'd218;
   localparam logic [7:0]  RST_COMMAND_TYPE_CODE  = 8'd192;
   localparam logic [7:0]  RST_RESPONSE_TYPE_CODE = 8'd170;

   typedef struct packed {
      logic [15:0] buffer_capacity;
      logic [7:0]  start_code;
      logic [7:0]  end_code;
      logic [7:0]  data_type_code;
      logic [7:0]  command_type_code;
      logic [7:0]  response_type_code;
   } lpf_cfg_type;

   typedef enum logic [2:0] {
      PH_WAIT   = 3'd0,
      PH_TYPE   = 3'd1,
      PH_LEN_HI = 3'd2,
      PH_LEN_LO = 3'd3,
      PH_DATA   = 3'd4,
      PH_END    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_CMD  = 2'd1,
      KIND_RESP = 2'd2
   } kind_type;

endpackage

### hw/rtl/lpf_csr.sv
// Configuration registers of the LED frame stream parser.
// Depends on lpf_pkg for the register indexes, reset values and lpf_cfg_type.
module lpf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lpf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output lpf_pkg::lpf_cfg_type             cfg
);
   import lpf_pkg::*;

   lpf_cfg_type cfg_ff;
   lpf_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BUFFER_CAPACITY:    cfg_in.buffer_capacity    = csr_wdata;
            CSR_START_CODE:         cfg_in.start_code         = csr_wdata[7:0];
            CSR_END_CODE:           cfg_in.end_code           = csr_wdata[7:0];
            CSR_DATA_TYPE_CODE:     cfg_in.data_type_code     = csr_wdata[7:0];
            CSR_COMMAND_TYPE_CODE:  cfg_in.command_type_code  = csr_wdata[7:0];
            CSR_RESPONSE_TYPE_CODE: cfg_in.response_type_code = csr_wdata[7:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_capacity    <= RST_BUFFER_CAPACITY;
         cfg_ff.start_code         <= RST_START_CODE;
         cfg_ff.end_code           <= RST_END_CODE;
         cfg_ff.data_type_code     <= RST_DATA_TYPE_CODE;
         cfg_ff.command_type_code  <= RST_COMMAND_TYPE_CODE;
         cfg_ff.response_type_code <= RST_RESPONSE_TYPE_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/led_frame_stream_parser.sv
// LED frame stream parser: top level with the frame state machine and result register.
// Depends on lpf_pkg and lpf_csr.
//
// Usage:
//   req_* carries one received serial byte per transfer. rsp_* carries exactly one
//   result per accepted byte: a buffer write (payload byte and its index) when
//   rsp_tuser[0] is set, and a frame done pulse with the clamped length when
//   rsp_tuser[1] is set; fields without their flag read as zero.
//   csr_* writes the capacity, start, end and type codes; write only while idle.
//   The result enters the output register in the cycle after the transfer. Throughput:
//   one byte per cycle while results are taken; the state machine updates phase, length
//   and count in the same cycle the byte is taken, so the next byte may follow at once.
//   When the receiver stalls, the result is held and req_tready drops until the
//   waiting result is taken; a byte is still accepted in the cycle it leaves.
//   Reset (synchronous, active high) restores the register defaults, empties the
//   output register and returns the parser to hunting for the start byte.
module led_frame_stream_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] rx_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [39:0]                      rsp_tdata,   // [15:0] write_index,
                                                         // [23:16] write_byte,
                                                         // [39:24] frame_length
   output logic [1:0]                       rsp_tuser,   // [0] write_enable,
                                                         // [1] frame_done
   input  logic                             csr_we,
   input  logic [lpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lpf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lpf_pkg::*;

   lpf_cfg_type cfg;

   lpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   phase_type   phase_ff, phase_in;
   kind_type    kind_ff, kind_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        we_ff, we_in;
   logic [15:0] widx_ff, widx_in;
   logic [7:0]  wbyte_ff, wbyte_in;
   logic        done_ff, done_in;
   logic [15:0] flen_ff, flen_in;

   logic        req_fire;
   logic [7:0]  rx_byte;
   logic [15:0] count_inc;
   logic [15:0] full_length;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rx_byte    = req_tdata;
   assign count_inc  = count_ff + 16'd1;
   assign full_length = {length_ff[15:8], rx_byte};

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      length_in = length_ff;
      count_in  = count_ff;
      we_in     = 1'b0;
      widx_in   = '0;
      wbyte_in  = '0;
      done_in   = 1'b0;
      flen_in   = '0;
      if (req_fire) begin
         case (phase_ff)
            PH_TYPE: begin
               phase_in = PH_LEN_HI;
               if (rx_byte == cfg.data_type_code) begin
                  kind_in = KIND_DATA;
               end else if (rx_byte == cfg.command_type_code) begin
                  kind_in = KIND_CMD;
               end else if (rx_byte == cfg.response_type_code) begin
                  kind_in = KIND_RESP;
               end else begin
                  phase_in = PH_WAIT;
               end
            end
            PH_LEN_HI: begin
               length_in = {rx_byte, 8'd0};
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_in = full_length;
               count_in  = '0;
               // skip the payload phase for an empty frame
               phase_in  = (full_length == 16'd0) ? PH_END : PH_DATA;
            end
            PH_DATA: begin
               if (count_ff < cfg.buffer_capacity) begin
                  we_in    = 1'b1;
                  widx_in  = count_ff;
                  wbyte_in = rx_byte;
               end
               count_in = count_inc;
               if (count_inc == length_ff) begin
                  phase_in = PH_END;
               end
            end
            PH_END: begin
               if (rx_byte == cfg.end_code && kind_ff == KIND_DATA) begin
                  done_in = 1'b1;
                  flen_in = (length_ff < cfg.buffer_capacity) ? length_ff
                                                              : cfg.buffer_capacity;
               end
               phase_in = PH_WAIT;
            end
            default: begin
               phase_in = (rx_byte == cfg.start_code) ? PH_TYPE : PH_WAIT;
            end
         endcase
      end
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         kind_ff      <= KIND_DATA;
         length_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result register on each input transfer, hold it otherwise
   always_ff @(posedge clock) begin
      if (req_fire) begin
         we_ff    <= we_in;
         widx_ff  <= widx_in;
         wbyte_ff <= wbyte_in;
         done_ff  <= done_in;
         flen_ff  <= flen_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {flen_ff, wbyte_ff, widx_ff};
   assign rsp_tuser  = {done_ff, we_ff};

endmodule

### test/lpf_parse_checker.sv
// Checker for led_frame_stream_parser: watches the byte, result and register ports,
// predicts one result per accepted byte and compares it with what the block returns.
// Depends on lpf_pkg.
`timescale 1ns / 1ps

module lpf_parse_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] rx_byte
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [39:0]                    rsp_tdata,   // [15:0] write_index,
                                                       // [23:16] write_byte,
                                                       // [39:24] frame_length
   input  logic [1:0]                     rsp_tuser,   // [0] write_enable, [1] frame_done
   input  logic                           csr_we,
   input  logic [lpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lpf_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             error_count,
   output int                             open_count
);
   import lpf_pkg::*;

   typedef struct packed {
      logic        wr_en;
      logic [15:0] wr_idx;
      logic [7:0]  wr_byte;
      logic        done;
      logic [15:0] done_len;
   } parse_result_type;

   parse_result_type parse_results_due[$];

   lpf_cfg_type regs;
   phase_type   frame_phase;
   kind_type    frame_kind;
   logic [15:0] length_field;
   logic [15:0] payload_count;

   function automatic parse_result_type parse_rx_byte(input logic [7:0] b);
      parse_result_type r;
      r = '0;
      case (frame_phase)
         PH_TYPE: begin
            // first matching code wins when codes are equal
            if (b == regs.data_type_code) begin
               frame_kind  = KIND_DATA;
               frame_phase = PH_LEN_HI;
            end else if (b == regs.command_type_code) begin
               frame_kind  = KIND_CMD;
               frame_phase = PH_LEN_HI;
            end else if (b == regs.response_type_code) begin
               frame_kind  = KIND_RESP;
               frame_phase = PH_LEN_HI;
            end else begin
               frame_phase = PH_WAIT;
            end
         end
         PH_LEN_HI: begin
            length_field = {b, 8'h00};
            frame_phase  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_field  = {length_field[15:8], b};
            payload_count = '0;
            frame_phase   = (length_field == 16'd0) ? PH_END : PH_DATA;
         end
         PH_DATA: begin
            if (payload_count < regs.buffer_capacity) begin
               r.wr_en   = 1'b1;
               r.wr_idx  = payload_count;
               r.wr_byte = b;
            end
            payload_count = payload_count + 16'd1;
            if (payload_count == length_field) frame_phase = PH_END;
         end
         PH_END: begin
            if (b == regs.end_code && frame_kind == KIND_DATA) begin
               r.done     = 1'b1;
               r.done_len = (length_field < regs.buffer_capacity) ? length_field
                                                                  : regs.buffer_capacity;
            end
            frame_phase = PH_WAIT;
         end
         default: frame_phase = (b == regs.start_code) ? PH_TYPE : PH_WAIT;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      parse_result_type want;
      parse_result_type got;
      if (reset) begin
         parse_results_due.delete();
         regs.buffer_capacity    = RST_BUFFER_CAPACITY;
         regs.start_code         = RST_START_CODE;
         regs.end_code           = RST_END_CODE;
         regs.data_type_code     = RST_DATA_TYPE_CODE;
         regs.command_type_code  = RST_COMMAND_TYPE_CODE;
         regs.response_type_code = RST_RESPONSE_TYPE_CODE;
         frame_phase   = PH_WAIT;
         frame_kind    = KIND_DATA;
         length_field  = '0;
         payload_count = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BUFFER_CAPACITY:    regs.buffer_capacity    = csr_wdata;
               CSR_START_CODE:         regs.start_code         = csr_wdata[7:0];
               CSR_END_CODE:           regs.end_code           = csr_wdata[7:0];
               CSR_DATA_TYPE_CODE:     regs.data_type_code     = csr_wdata[7:0];
               CSR_COMMAND_TYPE_CODE:  regs.command_type_code  = csr_wdata[7:0];
               CSR_RESPONSE_TYPE_CODE: regs.response_type_code = csr_wdata[7:0];
               default: ;
            endcase
         end

         // check the result transfer before queuing this cycle's byte
         if (rsp_tvalid && rsp_tready) begin
            got.wr_en    = rsp_tuser[0];
            got.done     = rsp_tuser[1];
            got.wr_idx   = rsp_tdata[15:0];
            got.wr_byte  = rsp_tdata[23:16];
            got.done_len = rsp_tdata[39:24];
            if (parse_results_due.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected result we=%0b idx=%0d byte=%02h done=%0b len=%0d",
                           $realtime, got.wr_en, got.wr_idx, got.wr_byte, got.done,
                           got.done_len);
               error_count <= error_count + 1;
            end else begin
               want = parse_results_due.pop_front();
               if (got !== want) begin
                  if (error_count < 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected we=%0b idx=%0d byte=%02h done=%0b len=%0d",
                              want.wr_en, want.wr_idx, want.wr_byte, want.done,
                              want.done_len);
                     $display("   actual   we=%0b idx=%0d byte=%02h done=%0b len=%0d",
                              got.wr_en, got.wr_idx, got.wr_byte, got.done, got.done_len);
                  end
                  error_count <= error_count + 1;
               end
            end
         end

         if (req_tvalid && req_tready) parse_results_due.push_back(parse_rx_byte(req_tdata));
      end
      open_count <= parse_results_due.size();
   end

endmodule

### test/tb_led_frame_stream_parser.sv
// Top of the led_frame_stream_parser testbench: clock, reset, byte and register stimulus,
// random back-pressure and the final verdict. Uses lpf_pkg, lpf_parse_checker, the DUT.
`timescale 1ns / 1ps

module tb_led_frame_stream_parser;
   import lpf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [39:0]           rsp_tdata;   // [15:0] write_index, [23:16] write_byte,
                                       // [39:24] frame_length
   logic [1:0]            rsp_tuser;   // [0] write_enable, [1] frame_done
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int          error_count;
   int          open_count;
   logic        idle_on = 1'b1;
   int unsigned bytes_sent;
   logic [7:0]  cur_start, cur_end, cur_data, cur_cmd, cur_resp;

   led_frame_stream_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lpf_parse_checker u_parse_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .open_count  (open_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_on || ($urandom_range(0, 99) >= 31);
      end
   end

   initial begin
      #400000;
      $display("tb_led_frame_stream_parser failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      while (idle_on && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] start_byte, input logic [7:0] type_byte,
                             input logic [15:0] len, input logic [7:0] end_byte);
      send_byte(start_byte);
      send_byte(type_byte);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
      send_byte(end_byte);
   endtask

   task automatic send_random_frame();
      int unsigned pick;
      int unsigned sel;
      logic [7:0]  type_byte;
      logic [7:0]  end_byte;
      logic [15:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         // line noise between frames
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 40)      type_byte = cur_data;
         else if (sel < 62) type_byte = cur_cmd;
         else if (sel < 84) type_byte = cur_resp;
         else               type_byte = 8'($urandom_range(0, 255));
         sel = $urandom_range(0, 99);
         if (sel < 10)      len = 16'd0;
         else if (sel < 85) len = 16'($urandom_range(1, 10));
         else if (sel < 97) len = 16'($urandom_range(11, 24));
         else               len = 16'($urandom_range(25, 40));
         end_byte = ($urandom_range(0, 99) < 75) ? cur_end : 8'($urandom_range(0, 255));
         // a corrupted start byte turns the whole frame into noise
         send_frame((pick < 10) ? cur_start ^ 8'h01 : cur_start, type_byte, len, end_byte);
      end
   endtask

   // hold the sender until every queued result has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] capacity, input logic [7:0] start_b,
                                 input logic [7:0] end_b, input logic [7:0] data_b,
                                 input logic [7:0] cmd_b, input logic [7:0] resp_b);
      logic [CSR_IDX_W-1:0]  idx  [8];
      logic [CSR_DATA_W-1:0] vals [8];
      idx  = '{CSR_BUFFER_CAPACITY, CSR_START_CODE, CSR_END_CODE, CSR_DATA_TYPE_CODE,
               CSR_COMMAND_TYPE_CODE, CSR_RESPONSE_TYPE_CODE, CSR_IDX_SPARE_LO,
               CSR_IDX_SPARE_HI};
      vals = '{capacity, {8'h00, start_b}, {8'h00, end_b}, {8'h00, data_b},
               {8'h00, cmd_b}, {8'h00, resp_b}, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535))};
      drain_results();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we    <= 1'b0;
      cur_start = start_b;
      cur_end   = end_b;
      cur_data  = data_b;
      cur_cmd   = cmd_b;
      cur_resp  = resp_b;
   endtask

   initial begin : stimulus
      logic [7:0]  directed_bytes [25];
      int unsigned phase_end;
      bit          paused;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      bytes_sent = 0;
      paused     = 1'b0;
      cur_start  = RST_START_CODE;
      cur_end    = RST_END_CODE;
      cur_data   = RST_DATA_TYPE_CODE;
      cur_cmd    = RST_COMMAND_TYPE_CODE;
      cur_resp   = RST_RESPONSE_TYPE_CODE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // data frame with extreme payload, zero-length data frame, unknown type,
      // command frame, zero-length response frame closed by a wrong end byte
      directed_bytes = '{
         RST_START_CODE, RST_DATA_TYPE_CODE, 8'h00, 8'h02, 8'h00, 8'hFF, RST_END_CODE,
         RST_START_CODE, RST_DATA_TYPE_CODE, 8'h00, 8'h00, RST_END_CODE,
         RST_START_CODE, 8'h11,
         RST_START_CODE, RST_COMMAND_TYPE_CODE, 8'h00, 8'h01, 8'h80, RST_END_CODE,
         RST_START_CODE, RST_RESPONSE_TYPE_CODE, 8'h00, 8'h00, RST_END_CODE ^ 8'h01};
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      for (int p = 0; p < 7; p++) begin
         case (p)
            1: apply_settings(16'd0, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01);
            2: apply_settings(16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80);
            3: apply_settings(16'd3, 8'hA5, 8'h5A, 8'h11, 8'h11, 8'h11);
            4: apply_settings(16'd8, 8'h7E, 8'h7F, 8'h22, 8'h33, 8'h33);
            5: apply_settings(16'd1, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h3C);
            6: apply_settings(16'($urandom_range(0, 16)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            default: ;
         endcase
         idle_on <= (p != 3);
         if (p == 2) send_frame(cur_start, cur_data, 16'd300, cur_end);
         phase_end = bytes_sent + 165;
         while (bytes_sent < phase_end) begin
            if (p == 4 && !paused && bytes_sent + 80 > phase_end) begin
               drain_results();
               paused = 1'b1;
            end
            send_random_frame();
         end
      end

      drain_results();
      if (error_count == 0 && open_count == 0) begin
         $display("tb_led_frame_stream_parser passed");
      end else begin
         $display("tb_led_frame_stream_parser failed");
      end
      $finish;
   end

endmodule
